// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl, empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, prop)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/mhc_pkg.sv -----
// shared types, constants and tables of the heading calibrator
`timescale 1ns / 1ps
package mhc_pkg;

  localparam logic [23:0] GAIN_MAX  = 24'hFFFFFF;
  localparam logic [14:0] HEAD_FULL = 15'd23040;

  typedef enum logic [1:0] {
    CFG_AXIS_LAYOUT = 2'd0,
    CFG_CAL_LENGTH  = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_DEFAULT = 2'd0,
    AXIS_X       = 2'd1,
    AXIS_Y       = 2'd2,
    AXIS_Z       = 2'd3
  } axis_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAP, ST_CORR, ST_MULY, ST_MULZ, ST_RNDZ, ST_CINIT, ST_CITER,
    ST_HMUL, ST_HFIN, ST_WIN, ST_DLDY, ST_DIVY, ST_DLDZ, ST_DIVZ, ST_DFIN
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic map;
    logic corr;
    logic mul_y;
    logic mul_z;
    logic rnd_z;
    logic cinit;
    logic citer;
    logic hmul;
    logic hfin;
    logic win;
    logic div_ld_y;
    logic div_ld_z;
    logic div_step;
    logic gy_wr;
    logic gz_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic win_hit;
    logic iter_last;
    logic div_last;
    logic out_free;
  } sts_t;

  // per layout negate mask, bit 0 x, bit 1 y, bit 2 z
  function automatic logic [2:0] lay_neg(input logic [2:0] lay);
    logic [2:0] r;
    unique case (lay)
      3'd0: r = 3'b000;
      3'd1: r = 3'b001;
      3'd2: r = 3'b011;
      3'd3: r = 3'b010;
      3'd4: r = 3'b101;
      3'd5: r = 3'b100;
      3'd6: r = 3'b110;
      3'd7: r = 3'b111;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

  // atan(2^-i), 2^32 per full turn
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/mhc_ctrl.sv -----
// sequencer for one sample: correction, cordic, heading, calibration window
`timescale 1ns / 1ps
module mhc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mhc_pkg::sts_t sts_i,
  output mhc_pkg::cmd_t cmd_o
);

  mhc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      mhc_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.load = 1'b1;
          state_d    = mhc_pkg::ST_MAP;
        end
      end
      mhc_pkg::ST_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = mhc_pkg::ST_CORR;
      end
      mhc_pkg::ST_CORR: begin
        cmd_o.corr = 1'b1;
        state_d    = mhc_pkg::ST_MULY;
      end
      mhc_pkg::ST_MULY: begin
        cmd_o.mul_y = 1'b1;
        state_d     = mhc_pkg::ST_MULZ;
      end
      mhc_pkg::ST_MULZ: begin
        cmd_o.mul_z = 1'b1;
        state_d     = mhc_pkg::ST_RNDZ;
      end
      mhc_pkg::ST_RNDZ: begin
        cmd_o.rnd_z = 1'b1;
        state_d     = mhc_pkg::ST_CINIT;
      end
      mhc_pkg::ST_CINIT: begin
        cmd_o.cinit = 1'b1;
        state_d     = mhc_pkg::ST_CITER;
      end
      mhc_pkg::ST_CITER: begin
        cmd_o.citer = 1'b1;
        if (sts_i.iter_last) begin
          state_d = mhc_pkg::ST_HMUL;
        end
      end
      mhc_pkg::ST_HMUL: begin
        cmd_o.hmul = 1'b1;
        state_d    = mhc_pkg::ST_HFIN;
      end
      mhc_pkg::ST_HFIN: begin
        cmd_o.hfin = 1'b1;
        state_d    = sts_i.win_hit ? mhc_pkg::ST_WIN : mhc_pkg::ST_DFIN;
      end
      mhc_pkg::ST_WIN: begin
        cmd_o.win = 1'b1;
        state_d   = mhc_pkg::ST_DLDY;
      end
      mhc_pkg::ST_DLDY: begin
        cmd_o.div_ld_y = 1'b1;
        state_d        = mhc_pkg::ST_DIVY;
      end
      mhc_pkg::ST_DIVY: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = mhc_pkg::ST_DLDZ;
        end
      end
      mhc_pkg::ST_DLDZ: begin
        cmd_o.gy_wr    = 1'b1;
        cmd_o.div_ld_z = 1'b1;
        state_d        = mhc_pkg::ST_DIVZ;
      end
      mhc_pkg::ST_DIVZ: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = mhc_pkg::ST_DFIN;
        end
      end
      mhc_pkg::ST_DFIN: begin
        // gain z write only matters after a window, harmless otherwise
        cmd_o.gz_wr = sts_i.win_hit;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = mhc_pkg::ST_IDLE;
        end
      end
      default: state_d = mhc_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/mhc_dp.sv -----
// datapath: layout, offset and gain, cordic, min/max tracking, divider, output word
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mhc_dp #(
  parameter int CORDIC_STEPS       = 16,
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mhc_pkg::cmd_t cmd_i,
  output mhc_pkg::sts_t sts_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_addr_i,
  input  logic [9:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  input  logic [47:0]   in_data_i,
  input  logic          in_cal_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [87:0]   out_data_o,
  output logic [2:0]    out_user_o
);

  localparam int F   = GAIN_FRACTION_BITS;
  localparam int PW  = 44;
  localparam int CW  = 50;
  localparam int IW  = $clog2(CORDIC_STEPS);
  localparam int DW  = 17 + F;
  localparam int DCW = $clog2(DW);
  localparam logic [63:0] GY_W = (F >= 16) ? (64'd67534 << ((F >= 16) ? F - 16 : 0))
    : ((64'd67534 + (64'd1 << ((F < 16) ? 15 - F : 0))) >> ((F < 16) ? 16 - F : 0));
  localparam logic [63:0] GZ_W = (F >= 16) ? (64'd51229 << ((F >= 16) ? F - 16 : 0))
    : ((64'd51229 + (64'd1 << ((F < 16) ? 15 - F : 0))) >> ((F < 16) ? 16 - F : 0));
  localparam logic [23:0] GY_RST = (GY_W > 64'hFFFFFF) ? mhc_pkg::GAIN_MAX : GY_W[23:0];
  localparam logic [23:0] GZ_RST = (GZ_W > 64'hFFFFFF) ? mhc_pkg::GAIN_MAX : GZ_W[23:0];

  // configuration and coefficients
  logic [2:0]         lay_q;
  logic [9:0]         len_q;
  logic signed [17:0] off_q [3];
  logic [23:0]        gy_q, gz_q;
  logic [1:0]         axis_q;
  logic signed [15:0] min_q [3];
  logic signed [15:0] max_q [3];
  logic [9:0]         cnt_q;

  // per sample working registers
  logic signed [15:0] raw_q [3];
  logic               cal_q;
  logic signed [15:0] m_q [3];
  logic signed [23:0] c0_q, cy_q, cz_q;
  logic signed [18:0] ty_q, tz_q;
  logic signed [PW-1:0] prod_q;
  logic signed [CW-1:0] x_q, y_q;
  logic [31:0]        z_q;
  logic [IW-1:0]      it_q;
  logic               zero_q;
  logic [1:0]         used_q;
  logic [46:0]        hp_q;
  logic [14:0]        head_q;
  logic               done_q;
  logic [15:0]        rng_q [3];
  logic [15:0]        den_q;
  logic [15:0]        rem_q;
  logic [DW-1:0]      dq_q;
  logic [DCW-1:0]     dcnt_q;
  logic               ovld_q;
  logic [87:0]        odata_q;
  logic [2:0]         ouser_q;

  // layout: odd layouts swap x and y, then negate with saturation
  logic [2:0]         neg;
  logic signed [15:0] src [3];
  logic signed [15:0] m_d [3];
  always_comb begin
    neg    = mhc_pkg::lay_neg(lay_q);
    src[0] = lay_q[0] ? raw_q[1] : raw_q[0];
    src[1] = lay_q[0] ? raw_q[0] : raw_q[1];
    src[2] = raw_q[2];
    for (int k = 0; k < 3; k++) begin
      if (!neg[k]) begin
        m_d[k] = src[k];
      end else if (src[k] == 16'sh8000) begin
        m_d[k] = 16'sh7FFF;
      end else begin
        m_d[k] = -src[k];
      end
    end
  end

  logic win_hit;
  assign win_hit = ({1'b0, cnt_q} + 11'd1) >= {1'b0, len_q};

  // shared gain multiplier and its rounding
  logic signed [18:0]   mul_a;
  logic signed [24:0]   mul_b;
  logic signed [PW-1:0] prod_d;
  logic signed [PW-1:0] prod_r;
  logic signed [23:0]   gain_sat;
  always_comb begin
    mul_a  = cmd_i.mul_y ? ty_q : tz_q;
    mul_b  = signed'({1'b0, (cmd_i.mul_y ? gy_q : gz_q)});
    prod_d = PW'(mul_a) * PW'(mul_b);
    prod_r = (prod_q + (PW'(1) <<< (F - 1))) >>> F;
    if (prod_r > PW'(24'sh7FFFFF)) begin
      gain_sat = 24'sh7FFFFF;
    end else if (prod_r < -PW'(24'sh7FFFFF) - PW'(1)) begin
      gain_sat = 24'sh800000;
    end else begin
      gain_sat = prod_r[23:0];
    end
  end

  // cordic operand pick and one vectoring step
  logic signed [23:0]   op_a, op_b;
  logic signed [CW-1:0] xi, yi, xs, ys;
  logic [31:0]          at;
  always_comb begin
    case (axis_q)
      mhc_pkg::AXIS_X: begin op_a = cy_q; op_b = cz_q; end
      mhc_pkg::AXIS_Y: begin op_a = c0_q; op_b = cz_q; end
      default:         begin op_a = cy_q; op_b = c0_q; end
    endcase
    xi = CW'(op_b) <<< 24;
    yi = CW'(op_a) <<< 24;
    xs = x_q >>> it_q;
    ys = y_q >>> it_q;
    at = mhc_pkg::atan_lut(5'(it_q));
  end

  logic [47:0] hsum;
  assign hsum = {1'b0, hp_q} + 48'h0000_8000_0000;

  // divider step
  logic [16:0] rs;
  logic        ge;
  logic [23:0] q_sat;
  always_comb begin
    rs    = {rem_q, dq_q[DW-1]};
    ge    = rs >= {1'b0, den_q};
    q_sat = ((den_q == 16'd0) || (|dq_q[DW-1:24])) ? mhc_pkg::GAIN_MAX : dq_q[23:0];
  end

  logic [15:0] rng_d [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rng_d[k] = 16'(17'(max_q[k]) - 17'(min_q[k]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lay_q  <= '0;
      len_q  <= 10'd999;
      off_q  <= '{18'sd653, -18'sd30, -18'sd167};
      gy_q   <= GY_RST;
      gz_q   <= GZ_RST;
      axis_q <= mhc_pkg::AXIS_DEFAULT;
      min_q  <= '{3{16'sh7FFF}};
      max_q  <= '{3{16'sh8000}};
      cnt_q  <= '0;
      ovld_q <= 1'b0;
      dcnt_q <= '0;
      it_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          mhc_pkg::CFG_AXIS_LAYOUT: lay_q <= cfg_wdata_i[2:0];
          mhc_pkg::CFG_CAL_LENGTH:  len_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.corr && cal_q) begin
        for (int k = 0; k < 3; k++) begin
          if (m_q[k] < min_q[k]) min_q[k] <= m_q[k];
          if (m_q[k] > max_q[k]) max_q[k] <= m_q[k];
        end
        if (!win_hit) begin
          cnt_q <= cnt_q + 10'd1;
        end
      end
      if (cmd_i.win) begin
        for (int k = 0; k < 3; k++) begin
          off_q[k] <= -(18'(max_q[k]) + 18'(min_q[k]));
        end
        if (rng_d[0] <= rng_d[1] && rng_d[0] <= rng_d[2]) begin
          axis_q <= mhc_pkg::AXIS_X;
        end else if (rng_d[1] <= rng_d[0] && rng_d[1] <= rng_d[2]) begin
          axis_q <= mhc_pkg::AXIS_Y;
        end else begin
          axis_q <= mhc_pkg::AXIS_Z;
        end
        min_q <= '{3{16'sh7FFF}};
        max_q <= '{3{16'sh8000}};
        cnt_q <= '0;
      end
      if (cmd_i.gy_wr) gy_q <= q_sat;
      if (cmd_i.gz_wr) gz_q <= q_sat;
      if (cmd_i.cinit) it_q <= '0;
      else if (cmd_i.citer) it_q <= it_q + IW'(1);
      if (cmd_i.div_ld_y || cmd_i.div_ld_z) dcnt_q <= '0;
      else if (cmd_i.div_step) dcnt_q <= dcnt_q + DCW'(1);
      if (cmd_i.out_load) ovld_q <= 1'b1;
      else if (out_ready_i) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q[0] <= in_data_i[15:0];
      raw_q[1] <= in_data_i[31:16];
      raw_q[2] <= in_data_i[47:32];
      cal_q    <= in_cal_i;
    end
    if (cmd_i.map) m_q <= m_d;
    if (cmd_i.corr) begin
      c0_q   <= 24'(19'(m_q[0]) * 19'sd2 + 19'(off_q[0]));
      ty_q   <= 19'(m_q[1]) * 19'sd2 + 19'(off_q[1]);
      tz_q   <= 19'(m_q[2]) * 19'sd2 + 19'(off_q[2]);
      done_q <= cal_q && win_hit;
    end
    if (cmd_i.mul_y || cmd_i.mul_z) prod_q <= prod_d;
    if (cmd_i.mul_z) cy_q <= gain_sat;
    if (cmd_i.rnd_z) cz_q <= gain_sat;
    if (cmd_i.cinit) begin
      zero_q <= (op_a == 24'sd0) && (op_b == 24'sd0);
      used_q <= axis_q;
      if (xi < 0) begin
        x_q <= -xi;
        y_q <= -yi;
        z_q <= 32'h8000_0000;
      end else begin
        x_q <= xi;
        y_q <= yi;
        z_q <= 32'h0;
      end
    end else if (cmd_i.citer) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end
    if (cmd_i.hmul) hp_q <= 47'(z_q) * 47'(mhc_pkg::HEAD_FULL);
    if (cmd_i.hfin) begin
      if (zero_q || hsum[47:32] >= {1'b0, mhc_pkg::HEAD_FULL}) begin
        head_q <= '0;
      end else begin
        head_q <= hsum[46:32];
      end
    end
    if (cmd_i.win) rng_q <= rng_d;
    if (cmd_i.div_ld_y || cmd_i.div_ld_z) begin
      den_q <= rng_q[0];
      rem_q <= '0;
      dq_q  <= (DW'(cmd_i.div_ld_y ? rng_q[1] : rng_q[2]) << F) + DW'(rng_q[0] >> 1);
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? 16'(rs - {1'b0, den_q}) : rs[15:0];
      dq_q  <= {dq_q[DW-2:0], ge};
    end
    if (cmd_i.out_load) begin
      odata_q <= {1'b0, head_q, cz_q, cy_q, c0_q};
      ouser_q <= {used_q, done_q};
    end
  end

  always_comb begin
    sts_o.in_valid  = in_valid_i;
    sts_o.win_hit   = done_q;
    sts_o.iter_last = (it_q == IW'(CORDIC_STEPS - 1));
    sts_o.div_last  = (dcnt_q == DCW'(DW - 1));
    sts_o.out_free  = !ovld_q || out_ready_i;
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = odata_q;
  assign out_user_o  = ouser_q;

  `ASSERT_ALWAYS(a_head_range, !ovld_q || odata_q[86:72] < mhc_pkg::HEAD_FULL)
  `ASSERT_NEXT(a_win_clears, cmd_i.win, cnt_q == 10'd0 && min_q[0] == 16'sh7FFF)
  `ASSERT_NEXT(a_load_full, cmd_i.out_load, ovld_q)

endmodule

// ----- rtl/magnetometer_heading_calibrator_unit.sv -----
// top level of the magnetometer heading calibrator
//
//  channel  | dir | tdata (low bit up)                 | tuser
//  s_axis   | in  | raw_x, raw_y, raw_z                | calibrate
//  m_axis   | out | corrected_x/y/z, heading, pad      | calibration_done, heading_axis
//  cfg      | in  | index 0 axis_layout, 1 calibration_length
//
// a sample passes layout mapping, offset correction, gain, the cordic loop and heading
// a sample that closes a calibration window also runs the two gain divisions on
// the shared radix-2 divider
// the next sample is taken once the result sits in the output register
// a stalled output holds the sequencer in its last state; reset is asynchronous
`timescale 1ns / 1ps
module magnetometer_heading_calibrator_unit #(
  parameter int CORDIC_STEPS       = 16,
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // raw_x, raw_y, raw_z
  input  logic        s_axis_tuser_i,  // calibrate
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,  // corrected_x, corrected_y, corrected_z, heading
  output logic [2:0]  m_axis_tuser_o,  // calibration_done, heading_axis
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [9:0]  cfg_wdata_i
);

  mhc_pkg::cmd_t cmd;
  mhc_pkg::sts_t sts;

  mhc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  mhc_dp #(
    .CORDIC_STEPS       (CORDIC_STEPS),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_data_i   (s_axis_tdata_i),
    .in_cal_i    (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

  assign s_axis_tready_o = cmd.in_ready;

endmodule
